>>> design/plid_pkg.sv
// Shared types and constants for the positional list block.
// Depends on nothing; every other design file refers to it by scoped names.
package plid_pkg;

  localparam int unsigned CAPACITY_DEF  = 16;
  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned FUNC_W        = 2;

  // Operation codes carried on func
  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_READ   = 2'd2
  } func_e;

  // Controller states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;  // capture the request word
    logic exec;  // apply the captured request and register its result
  } ctrl_cmd_t;

endpackage

>>> design/plid_ctrl.sv
// Controller state machine for the positional list block.
// Depends on plid_pkg; drives command signals into plid_datapath.
module plid_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  output plid_pkg::ctrl_cmd_t  cmd_o
);

  plid_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      plid_pkg::ST_IDLE: begin
        if (start) state_d = plid_pkg::ST_EXEC;
      end
      plid_pkg::ST_EXEC: begin
        state_d = plid_pkg::ST_IDLE;
      end
      default: begin
        state_d = plid_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plid_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy       = (state_q != plid_pkg::ST_IDLE);
  assign cmd_o.load = start && !busy;
  assign cmd_o.exec = (state_q == plid_pkg::ST_EXEC);

endmodule

>>> design/plid_datapath.sv
// Datapath for the positional list block: request register, entry array,
// length counter and result registers. Depends on plid_pkg.
module plid_datapath #(
  parameter int unsigned CAPACITY  = plid_pkg::CAPACITY_DEF,
  parameter int unsigned WORD_BITS = plid_pkg::WORD_BITS_DEF,
  localparam int unsigned POS_W    = $clog2(CAPACITY + 2),
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1),
  localparam int unsigned IDX_W    = $clog2(CAPACITY)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  plid_pkg::ctrl_cmd_t          cmd_i,
  input  logic [plid_pkg::FUNC_W-1:0]  func_i,
  input  logic [POS_W-1:0]             position_i,
  input  logic signed [WORD_BITS-1:0]  value_i,
  output logic                         result_valid_o,
  output logic                         status_o,
  output logic [CNT_W-1:0]             count_o,
  output logic [CNT_W-1:0]             spare_o,
  output logic signed [WORD_BITS-1:0]  read_value_o
);

  logic [plid_pkg::FUNC_W-1:0] func_q;
  logic [POS_W-1:0]            pos_q;
  logic [WORD_BITS-1:0]        val_q;
  logic [WORD_BITS-1:0]        entries_q [CAPACITY];
  logic [CNT_W-1:0]            len_q, len_d;

  logic                        valid_q;
  logic                        status_q, status_d;
  logic [CNT_W-1:0]            count_q;
  logic [CNT_W-1:0]            spare_q;
  logic [WORD_BITS-1:0]        rdval_q, rdval_d;

  logic [POS_W-1:0]            len_ext;
  logic [POS_W-1:0]            p0;
  logic                        pos_nz;
  logic                        ins_ok, del_ok, rd_ok;
  logic                        do_ins, do_del;

  assign len_ext = POS_W'(len_q);
  assign p0      = pos_q - POS_W'(1);
  assign pos_nz  = (pos_q != '0);
  assign ins_ok  = (len_q < CNT_W'(CAPACITY)) && pos_nz && (pos_q <= len_ext + POS_W'(1));
  assign del_ok  = pos_nz && (pos_q <= len_ext);
  assign rd_ok   = del_ok;

  always_comb begin
    do_ins   = 1'b0;
    do_del   = 1'b0;
    status_d = 1'b1;
    rdval_d  = '0;
    len_d    = len_q;
    case (func_q)
      plid_pkg::FUNC_INSERT: begin
        if (ins_ok) begin
          do_ins   = 1'b1;
          status_d = 1'b0;
          len_d    = len_q + CNT_W'(1);
        end
      end
      plid_pkg::FUNC_DELETE: begin
        if (del_ok) begin
          do_del   = 1'b1;
          status_d = 1'b0;
          len_d    = len_q - CNT_W'(1);
        end
      end
      plid_pkg::FUNC_READ: begin
        if (rd_ok) begin
          status_d = 1'b0;
          rdval_d  = entries_q[p0[IDX_W-1:0]];
        end
      end
      default: begin
        status_d = 1'b1;
      end
    endcase
  end

  // Capture the request word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      pos_q  <= position_i;
      val_q  <= value_i;
    end
  end

  // Shift every entry in parallel: up from the position on insert, down on delete
  for (genvar i = 0; i < CAPACITY; i++) begin : g_entry
    logic [WORD_BITS-1:0] below_w;
    logic [WORD_BITS-1:0] above_w;
    if (i == 0) begin : g_first
      assign below_w = val_q;
    end else begin : g_mid
      assign below_w = entries_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign above_w = entries_q[i];
    end else begin : g_top
      assign above_w = entries_q[i+1];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.exec && do_ins) begin
        if (POS_W'(i) == p0) begin
          entries_q[i] <= val_q;
        end else if (POS_W'(i) > p0) begin
          entries_q[i] <= below_w;
        end
      end else if (cmd_i.exec && do_del) begin
        if (POS_W'(i) >= p0) begin
          entries_q[i] <= above_w;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.exec;
      if (cmd_i.exec) len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_d;
      count_q  <= len_d;
      spare_q  <= CNT_W'(CAPACITY) - len_d;
      rdval_q  <= rdval_d;
    end
  end

  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign count_o        = count_q;
  assign spare_o        = spare_q;
  assign read_value_o   = rdval_q;

endmodule

>>> design/positional_list_insert_delete.sv
// Positional list insert/delete/read. A word accepted when busy is low is captured in
// the request register, applied in the execute state, and its result strobed on
// result_valid_o. No new word is taken while busy holds for the single execute cycle
// in which the entry array shifts all entries in parallel and the length updates.
// The receiver cannot stall: each result shows for exactly one cycle.
// Reset (rst_ni low, asynchronous) clears the length and control; entries stay undefined.
module positional_list_insert_delete #(
  parameter int unsigned CAPACITY  = plid_pkg::CAPACITY_DEF,
  parameter int unsigned WORD_BITS = plid_pkg::WORD_BITS_DEF,
  localparam int unsigned POS_W    = $clog2(CAPACITY + 2),
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request word
  input  logic                         start,
  output logic                         busy,
  input  logic [plid_pkg::FUNC_W-1:0]  func_i,
  input  logic [POS_W-1:0]             position_i,
  input  logic signed [WORD_BITS-1:0]  value_i,
  // result word, one-cycle strobe
  output logic                         result_valid_o,
  output logic                         status_o,
  output logic [CNT_W-1:0]             count_o,
  output logic [CNT_W-1:0]             spare_o,
  output logic signed [WORD_BITS-1:0]  read_value_o
);

  plid_pkg::ctrl_cmd_t cmd;

  // Sequence each request: capture it, then execute it in the next cycle
  plid_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  // Hold the list, check the position, shift entries and register the result
  plid_datapath #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .func_i         (func_i),
    .position_i     (position_i),
    .value_i        (value_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .count_o        (count_o),
    .spare_o        (spare_o),
    .read_value_o   (read_value_o)
  );

endmodule

>>> test/tb_positional_list_insert_delete.sv
// Self-checking testbench for positional_list_insert_delete: insert, delete and read words
// against an in-bench list model, compare every result strobe field by field.
// Depends on plid_pkg and the positional_list_insert_delete RTL only.
module tb_positional_list_insert_delete;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP    = plid_pkg::CAPACITY_DEF;
  localparam int unsigned WORD_W = plid_pkg::WORD_BITS_DEF;
  localparam int unsigned POS_W  = $clog2(CAP + 2);
  localparam int unsigned CNT_W  = $clog2(CAP + 1);

  // func code 3 has no enum member; the block must refuse it
  localparam logic [plid_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam int unsigned STALL_LIMIT  = 1000;  // cycles with no handshake at all
  localparam int unsigned RANDOM_WORDS = 950;
  localparam int unsigned CALM_WORDS   = 150;   // tail of the run without gaps
  localparam int unsigned DRAIN_CYCLES = 8;     // quiet tail after the last result, for stray strobes

  // Random-phase steering: grow toward full, shrink toward empty, or mix
  typedef enum int {
    MODE_GROW,
    MODE_SHRINK,
    MODE_MIX
  } list_mode_e;

  // Holds the list model, the queue of pending results and the error tally
  class list_scoreboard;
    typedef struct {
      logic                     status;
      logic [CNT_W-1:0]         count;
      logic [CNT_W-1:0]         spare;
      logic signed [WORD_W-1:0] read_value;
    } list_result_t;

    logic signed [WORD_W-1:0] entries [CAP];
    int unsigned              list_len;
    list_result_t             pending_q[$];
    int unsigned              errors;
    int unsigned              n_insert, n_delete, n_read, n_refused;
    int unsigned              n_full, n_empty;

    function new();
      foreach (entries[i]) entries[i] = '0;
      list_len  = 0;
      errors    = 0;
      n_insert  = 0;
      n_delete  = 0;
      n_read    = 0;
      n_refused = 0;
      n_full    = 0;
      n_empty   = 0;
    endfunction

    // Apply one accepted word to the list model and queue its result
    function void note_request(logic [plid_pkg::FUNC_W-1:0] op, logic [POS_W-1:0] pos,
                               logic signed [WORD_W-1:0] val);
      list_result_t r;
      int           p;
      int           k;
      p            = int'(pos);
      r.status     = 1'b1;
      r.read_value = '0;
      if (op == plid_pkg::FUNC_INSERT) begin
        if (list_len < CAP && p >= 1 && p <= int'(list_len) + 1) begin
          for (k = int'(list_len); k >= p; k--) entries[k] = entries[k-1];
          entries[p-1] = val;
          list_len++;
          r.status = 1'b0;
          n_insert++;
          if (list_len == CAP) n_full++;
        end
      end else if (op == plid_pkg::FUNC_DELETE) begin
        if (p >= 1 && p <= int'(list_len)) begin
          for (k = p; k < int'(list_len); k++) entries[k-1] = entries[k];
          list_len--;
          r.status = 1'b0;
          n_delete++;
          if (list_len == 0) n_empty++;
        end
      end else if (op == plid_pkg::FUNC_READ) begin
        if (p >= 1 && p <= int'(list_len)) begin
          r.read_value = entries[p-1];
          r.status     = 1'b0;
          n_read++;
        end
      end
      if (r.status) n_refused++;
      r.count = CNT_W'(list_len);
      r.spare = CNT_W'(CAP - list_len);
      pending_q.push_back(r);
    endfunction

    // Print one line per mismatch and count it
    task report_mismatch(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
      $display("%0t MISMATCH %s: got %0h, want %0h", $realtime, what, got, want);
      errors++;
    endtask

    // Compare one strobed result with the oldest pending one
    task check_result(logic st, logic [CNT_W-1:0] cnt, logic [CNT_W-1:0] spr,
                      logic signed [WORD_W-1:0] rv);
      list_result_t want;
      if (pending_q.size() == 0) begin
        report_mismatch("result with nothing pending, read_value", rv, '0);
      end else begin
        want = pending_q.pop_front();
        if (st !== want.status)
          report_mismatch("status", WORD_W'(st), WORD_W'(want.status));
        if (cnt !== want.count)
          report_mismatch("count", WORD_W'(cnt), WORD_W'(want.count));
        if (spr !== want.spare)
          report_mismatch("spare", WORD_W'(spr), WORD_W'(want.spare));
        if (rv !== want.read_value) report_mismatch("read_value", rv, want.read_value);
      end
    endtask
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           start;
  logic                           busy;
  logic [plid_pkg::FUNC_W-1:0]    func_i;
  logic [POS_W-1:0]               position_i;
  logic signed [WORD_W-1:0]       value_i;
  logic                           result_valid_o;
  logic                           status_o;
  logic [CNT_W-1:0]               count_o;
  logic [CNT_W-1:0]               spare_o;
  logic signed [WORD_W-1:0]       read_value_o;

  list_scoreboard sb;
  int unsigned    quiet_cycles;
  bit             allow_gaps;

  positional_list_insert_delete u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .position_i     (position_i),
    .value_i        (value_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .count_o        (count_o),
    .spare_o        (spare_o),
    .read_value_o   (read_value_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Sample the result strobe at the rising edge; the receiver never stalls
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      sb.check_result(status_o, count_o, spare_o, read_value_o);
  end

  // Watchdog: end the run when neither side has moved for too long
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t watchdog: no handshake for %0d cycles, %0d results outstanding",
                 $realtime, STALL_LIMIT, sb.pending_q.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Present one word from a falling edge and hold it until the block takes it.
  // Entered and left just after a falling edge. Start stays high between
  // back-to-back words; a gap, when allowed, drops it first.
  task automatic send_word(logic [plid_pkg::FUNC_W-1:0] op, logic [POS_W-1:0] pos,
                           logic signed [WORD_W-1:0] val);
    int unsigned gap;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(negedge clk_i);
    end
    start      <= 1'b1;
    func_i     <= op;
    position_i <= pos;
    value_i    <= val;
    // wait out busy; the word is taken at the first edge that sees it low
    do @(posedge clk_i); while (busy);
    sb.note_request(op, pos, val);
    @(negedge clk_i);
  endtask

  // Pick a value: mostly random, sometimes the signed extremes
  function automatic logic signed [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(WORD_W-1){1'b0}}};
      1:       return {1'b0, {(WORD_W-1){1'b1}}};
      2:       return '1;
      default: return WORD_W'($urandom);
    endcase
  endfunction

  // Build and send one random word, steered by the current mode
  task automatic send_random_word(list_mode_e mode);
    int unsigned                 roll;
    int unsigned                 len;
    int unsigned                 ins_pct;
    int unsigned                 del_pct;
    logic [plid_pkg::FUNC_W-1:0] op;
    logic [POS_W-1:0]            pos;
    len  = sb.list_len;
    roll = $urandom_range(0, 99);
    // a slice of pure noise: any code, any position
    if (roll < 10) begin
      send_word(plid_pkg::FUNC_W'($urandom_range(0, 3)), POS_W'($urandom), pick_value());
      return;
    end
    case (mode)
      MODE_GROW:   begin ins_pct = 65; del_pct = 15; end
      MODE_SHRINK: begin ins_pct = 20; del_pct = 60; end
      default:     begin ins_pct = 35; del_pct = 30; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) begin
      op  = plid_pkg::FUNC_INSERT;
      pos = POS_W'($urandom_range(1, len + 1));
    end else begin
      op = (roll < ins_pct + del_pct) ? plid_pkg::FUNC_DELETE : plid_pkg::FUNC_READ;
      // mostly hold to the legal window; when it is empty, or now and then, probe just outside it
      if (len == 0 || $urandom_range(0, 19) == 0)
        pos = POS_W'($urandom_range(0, 1) ? len + 1 : 0);
      else
        pos = POS_W'($urandom_range(1, len));
    end
    send_word(op, pos, pick_value());
  endtask

  initial begin
    list_mode_e mode;
    int unsigned i;
    sb           = new();
    quiet_cycles = 0;
    allow_gaps   = 1'b0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    func_i       = plid_pkg::FUNC_INSERT;
    position_i   = '0;
    value_i      = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: refusals on an empty list
    send_word(plid_pkg::FUNC_READ,   1, '0);
    send_word(plid_pkg::FUNC_DELETE, 1, '0);
    send_word(plid_pkg::FUNC_INSERT, 0, 32'h1234_5678);
    send_word(plid_pkg::FUNC_INSERT, 2, 32'h1234_5678);
    // build a short list at the tail, the head and the middle
    send_word(plid_pkg::FUNC_INSERT, 1, 32'h8000_0000);
    send_word(plid_pkg::FUNC_INSERT, 2, 32'h7fff_ffff);
    send_word(plid_pkg::FUNC_INSERT, 1, 32'hffff_ffff);
    send_word(plid_pkg::FUNC_INSERT, 2, 32'h0000_0000);
    send_word(plid_pkg::FUNC_INSERT, 5, 32'h5a5a_a5a5);
    send_word(plid_pkg::FUNC_READ,   1, '0);
    send_word(plid_pkg::FUNC_READ,   3, '0);
    send_word(plid_pkg::FUNC_READ,   5, '0);
    // out-of-range positions and the unused code
    send_word(plid_pkg::FUNC_READ,   6, '0);
    send_word(plid_pkg::FUNC_READ,   0, '0);
    send_word(FUNC_UNUSED,           1, 32'hdead_beef);
    send_word(plid_pkg::FUNC_DELETE, 6, '0);
    send_word(plid_pkg::FUNC_INSERT, 31, 32'h0bad_f00d);
    // remove from the tail, the head and the middle
    send_word(plid_pkg::FUNC_DELETE, 5, '0);
    send_word(plid_pkg::FUNC_DELETE, 1, '0);
    send_word(plid_pkg::FUNC_DELETE, 2, '0);
    send_word(plid_pkg::FUNC_READ,   1, '0);
    send_word(plid_pkg::FUNC_READ,   2, '0);
    send_word(FUNC_UNUSED,           0, '1);

    // Random: swing the list between empty and full, gaps off for the tail
    allow_gaps = 1'b1;
    mode       = MODE_GROW;
    for (i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS - CALM_WORDS) allow_gaps = 1'b0;
      if (sb.list_len == CAP)
        mode = MODE_SHRINK;
      else if (sb.list_len == 0)
        mode = MODE_GROW;
      else if ($urandom_range(0, 39) == 0)
        mode = list_mode_e'($urandom_range(0, 2));
      send_random_word(mode);
    end
    start <= 1'b0;

    // Drain: wait for every result, then a few cycles for stray strobes
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d inserts, %0d deletes, %0d reads, %0d refused words",
             sb.n_insert, sb.n_delete, sb.n_read, sb.n_refused);
    $display("list reached capacity %0d times and emptied %0d times",
             sb.n_full, sb.n_empty);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
